>>> src/point_in_mesh_parity_top_defines.svh
// Assertion macros shared by the point-in-mesh parity RTL.
// No dependencies; included by the modules that assert.
`ifndef POINT_IN_MESH_PARITY_TOP_DEFINES_SVH
`define POINT_IN_MESH_PARITY_TOP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define PIMP_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define PIMP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/pimp_pkg.sv
// Shared constants and types for the point-in-mesh parity block.
// No dependencies.
package pimp_pkg;

    localparam int PORT_W    = 32;
    localparam int CW        = 32;
    localparam int FRAC      = 16;
    localparam int CNT_W     = 16;
    localparam int EPS_RECIP = 100000;
    localparam int EPS_W     = 17;

    // edge / offset width, multiplier operand width, product width
    localparam int DW   = CW + 1;
    localparam int OPW  = DW + 2;
    localparam int PRW  = 2 * OPW;
    // cross-product width, dot-product chunking, accumulator width
    localparam int QW   = 2 * DW + 1;
    localparam int TCH  = (QW + DW + 7) / 4;
    localparam int TW   = 4 * TCH;
    localparam int ACCW = TW + EPS_W + 8;

    // smallest |det| that passes the epsilon test
    localparam longint unsigned DET_MIN =
        ((64'd1 << (2 * FRAC)) + 64'(EPS_RECIP) - 64'd1) / 64'(EPS_RECIP);

    typedef enum logic [1:0] {
        REG_POINT_X = 2'd0,
        REG_POINT_Y = 2'd1,
        REG_POINT_Z = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic signed [DW-1:0] e1x;
        logic signed [DW-1:0] e1y;
        logic signed [DW-1:0] e1z;
        logic signed [DW-1:0] e2x;
        logic signed [DW-1:0] e2y;
        logic signed [DW-1:0] e2z;
        logic signed [DW-1:0] sx;
        logic signed [DW-1:0] sy;
        logic signed [DW-1:0] sz;
        logic                 last;
    } tri_t;

endpackage

>>> src/pimp_front.sv
// Front end: query point registers and per-item edge / offset setup.
// Depends on pimp_pkg.
module pimp_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [pimp_pkg::PORT_W-1:0]   cfg_data,
    input  logic [pimp_pkg::PORT_W-1:0]   vert0_x,
    input  logic [pimp_pkg::PORT_W-1:0]   vert0_y,
    input  logic [pimp_pkg::PORT_W-1:0]   vert0_z,
    input  logic [pimp_pkg::PORT_W-1:0]   vert1_x,
    input  logic [pimp_pkg::PORT_W-1:0]   vert1_y,
    input  logic [pimp_pkg::PORT_W-1:0]   vert1_z,
    input  logic [pimp_pkg::PORT_W-1:0]   vert2_x,
    input  logic [pimp_pkg::PORT_W-1:0]   vert2_y,
    input  logic [pimp_pkg::PORT_W-1:0]   vert2_z,
    input  logic                          last_triangle,
    output pimp_pkg::tri_t                tri_out
);

    logic [pimp_pkg::PORT_W-1:0] px_reg;
    logic [pimp_pkg::PORT_W-1:0] py_reg;
    logic [pimp_pkg::PORT_W-1:0] pz_reg;

    // low CW bits, sign-extended by one for the difference
    function automatic logic signed [pimp_pkg::DW-1:0] ext(
        input logic [pimp_pkg::PORT_W-1:0] r);
        return {r[pimp_pkg::CW-1], r[pimp_pkg::CW-1:0]};
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            px_reg <= '0;
            py_reg <= '0;
            pz_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (pimp_pkg::reg_idx_t'(cfg_index))
                pimp_pkg::REG_POINT_X: px_reg <= cfg_data;
                pimp_pkg::REG_POINT_Y: py_reg <= cfg_data;
                pimp_pkg::REG_POINT_Z: pz_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        tri_out.e1x  = ext(vert1_x) - ext(vert0_x);
        tri_out.e1y  = ext(vert1_y) - ext(vert0_y);
        tri_out.e1z  = ext(vert1_z) - ext(vert0_z);
        tri_out.e2x  = ext(vert2_x) - ext(vert0_x);
        tri_out.e2y  = ext(vert2_y) - ext(vert0_y);
        tri_out.e2z  = ext(vert2_z) - ext(vert0_z);
        tri_out.sx   = ext(px_reg) - ext(vert0_x);
        tri_out.sy   = ext(py_reg) - ext(vert0_y);
        tri_out.sz   = ext(pz_reg) - ext(vert0_z);
        tri_out.last = last_triangle;
    end

endmodule

>>> src/pimp_queue.sv
// Two-entry item queue between front and back.
// Depends on pimp_pkg.
module pimp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pimp_pkg::tri_t wr_data,
    input  logic           pop,
    output pimp_pkg::tri_t rd_data,
    output logic           full,
    output logic           empty
);

    pimp_pkg::tri_t mem_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     cnt_reg;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

>>> src/pimp_back.sv
// Back end: sequenced ray/triangle test on one shared multiplier,
// hit counter, parity and result register. Depends on pimp_pkg and the defines header.
`include "point_in_mesh_parity_top_defines.svh"

module pimp_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  pimp_pkg::tri_t             rd_data,
    input  logic                       empty,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       inside_res,
    output logic [pimp_pkg::CNT_W-1:0] hit_count
);

    localparam int OPW  = pimp_pkg::OPW;
    localparam int PRW  = pimp_pkg::PRW;
    localparam int QW   = pimp_pkg::QW;
    localparam int DW   = pimp_pkg::DW;
    localparam int TCH  = pimp_pkg::TCH;
    localparam int TW   = pimp_pkg::TW;
    localparam int ACCW = pimp_pkg::ACCW;
    localparam logic [4:0] LAST_STEP = 5'd21;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN, S_FIN} state_t;

    typedef enum logic [4:0] {
        OP_E1X, OP_E1Y, OP_E1Z, OP_E2X, OP_E2Y, OP_E2Z, OP_SX, OP_SY, OP_SZ,
        OP_QX_LO, OP_QX_HI, OP_QY_LO, OP_QY_HI, OP_QZ_LO, OP_QZ_HI,
        OP_T0, OP_T1, OP_T2, OP_T3, OP_EPS
    } opsel_t;

    typedef enum logic [2:0] {SH_0, SH_Q, SH_T1, SH_T2, SH_T3} shift_t;

    typedef enum logic [2:0] {
        DST_NONE, DST_DET, DST_U, DST_QX, DST_QY, DST_QZ, DST_T, DST_D
    } dst_t;

    typedef struct packed {
        opsel_t a_sel;
        opsel_t b_sel;
        logic   add_en;
        logic   clr;
        logic   neg;
        logic   negdet;
        logic   use_adet;
        shift_t sh;
        dst_t   dst;
    } ctl_t;

    function automatic ctl_t mk(input opsel_t a, input opsel_t b, input logic clr,
                                input logic neg, input logic negdet, input shift_t sh,
                                input dst_t dst);
        ctl_t c;
        c.a_sel    = a;
        c.b_sel    = b;
        c.add_en   = 1'b1;
        c.clr      = clr;
        c.neg      = neg;
        c.negdet   = negdet;
        c.use_adet = 1'b0;
        c.sh       = sh;
        c.dst      = dst;
        return c;
    endfunction

    // micro-program: det, u, q, then t = e2.q, then t*eps - |det|<<frac
    function automatic ctl_t step_ctl(input logic [4:0] s);
        ctl_t c;
        c        = mk(OP_E1X, OP_E1X, 1'b0, 1'b0, 1'b0, SH_0, DST_NONE);
        c.add_en = 1'b0;
        unique case (s)
            5'd0:  c = mk(OP_E1Z, OP_E2Y,   1'b1, 1'b0, 1'b0, SH_0,  DST_NONE);
            5'd1:  c = mk(OP_E1Y, OP_E2Z,   1'b0, 1'b1, 1'b0, SH_0,  DST_DET);
            5'd2:  c = mk(OP_SZ,  OP_E2Y,   1'b1, 1'b0, 1'b0, SH_0,  DST_NONE);
            5'd3:  c = mk(OP_SY,  OP_E2Z,   1'b0, 1'b1, 1'b0, SH_0,  DST_U);
            5'd4:  c = mk(OP_SY,  OP_E1Z,   1'b1, 1'b0, 1'b0, SH_0,  DST_NONE);
            5'd5:  c = mk(OP_SZ,  OP_E1Y,   1'b0, 1'b1, 1'b0, SH_0,  DST_QX);
            5'd6:  c = mk(OP_SZ,  OP_E1X,   1'b1, 1'b0, 1'b0, SH_0,  DST_NONE);
            5'd7:  c = mk(OP_SX,  OP_E1Z,   1'b0, 1'b1, 1'b0, SH_0,  DST_QY);
            5'd8:  c = mk(OP_SX,  OP_E1Y,   1'b1, 1'b0, 1'b0, SH_0,  DST_NONE);
            5'd9:  c = mk(OP_SY,  OP_E1X,   1'b0, 1'b1, 1'b0, SH_0,  DST_QZ);
            5'd10: c = mk(OP_E2X, OP_QX_LO, 1'b1, 1'b0, 1'b0, SH_0,  DST_NONE);
            5'd11: c = mk(OP_E2X, OP_QX_HI, 1'b0, 1'b0, 1'b0, SH_Q,  DST_NONE);
            5'd12: c = mk(OP_E2Y, OP_QY_LO, 1'b0, 1'b0, 1'b0, SH_0,  DST_NONE);
            5'd13: c = mk(OP_E2Y, OP_QY_HI, 1'b0, 1'b0, 1'b0, SH_Q,  DST_NONE);
            5'd14: c = mk(OP_E2Z, OP_QZ_LO, 1'b0, 1'b0, 1'b0, SH_0,  DST_NONE);
            5'd15: c = mk(OP_E2Z, OP_QZ_HI, 1'b0, 1'b0, 1'b0, SH_Q,  DST_T);
            5'd17: c = mk(OP_T0,  OP_EPS,   1'b1, 1'b0, 1'b1, SH_0,  DST_NONE);
            5'd18: c = mk(OP_T1,  OP_EPS,   1'b0, 1'b0, 1'b1, SH_T1, DST_NONE);
            5'd19: c = mk(OP_T2,  OP_EPS,   1'b0, 1'b0, 1'b1, SH_T2, DST_NONE);
            5'd20: c = mk(OP_T3,  OP_EPS,   1'b0, 1'b0, 1'b1, SH_T3, DST_NONE);
            5'd21:
            begin
                c          = mk(OP_E1X, OP_E1X, 1'b0, 1'b1, 1'b0, SH_0, DST_D);
                c.use_adet = 1'b1;
            end
            default: ;   // step 16 waits for t
        endcase
        return c;
    endfunction

    state_t                      state_reg;
    logic [4:0]                  step_reg;
    pimp_pkg::tri_t              tri_reg;
    ctl_t                        ctl_reg;
    logic signed [PRW-1:0]       prod_reg;
    logic signed [ACCW-1:0]      acc_reg;
    logic [QW-1:0]               det_reg;
    logic [QW-1:0]               u_reg;
    logic [QW-1:0]               qx_reg;
    logic [QW-1:0]               qy_reg;
    logic [QW-1:0]               qz_reg;
    logic [TW-1:0]               t_reg;
    logic                        d_pos_reg;
    logic                        pass_reg;
    logic [pimp_pkg::CNT_W-1:0]  cnt_reg;
    logic                        par_reg;
    logic                        out_valid_reg;
    logic                        inside_reg;
    logic [pimp_pkg::CNT_W-1:0]  count_reg;

    ctl_t                        ctl_issue;
    logic signed [OPW-1:0]       op_a;
    logic signed [OPW-1:0]       op_b;
    logic signed [PRW-1:0]       prod;
    logic                        detneg;
    logic signed [QW+1:0]        det_ext;
    logic signed [QW+1:0]        adet;
    logic signed [QW+1:0]        uadj;
    logic signed [QW+1:0]        vadj;
    logic signed [QW+1:0]        uv_sum;
    logic                        pass_next;
    logic signed [ACCW-1:0]      term;
    logic signed [ACCW-1:0]      acc_next;
    logic                        hit;
    logic                        fin_last;
    logic                        out_busy;
    logic [pimp_pkg::CNT_W-1:0]  cnt_next;
    logic                        par_next;

    function automatic logic signed [OPW-1:0] sel_op(input opsel_t s,
                                                     input pimp_pkg::tri_t tr,
                                                     input logic [QW-1:0] qx,
                                                     input logic [QW-1:0] qy,
                                                     input logic [QW-1:0] qz,
                                                     input logic [TW-1:0] t);
        logic signed [OPW-1:0] r;
        unique case (s)
            OP_E1X:   r = OPW'(tr.e1x);
            OP_E1Y:   r = OPW'(tr.e1y);
            OP_E1Z:   r = OPW'(tr.e1z);
            OP_E2X:   r = OPW'(tr.e2x);
            OP_E2Y:   r = OPW'(tr.e2y);
            OP_E2Z:   r = OPW'(tr.e2z);
            OP_SX:    r = OPW'(tr.sx);
            OP_SY:    r = OPW'(tr.sy);
            OP_SZ:    r = OPW'(tr.sz);
            OP_QX_LO: r = {2'b00, qx[DW-1:0]};
            OP_QX_HI: r = {qx[QW-1], qx[QW-1:DW]};
            OP_QY_LO: r = {2'b00, qy[DW-1:0]};
            OP_QY_HI: r = {qy[QW-1], qy[QW-1:DW]};
            OP_QZ_LO: r = {2'b00, qz[DW-1:0]};
            OP_QZ_HI: r = {qz[QW-1], qz[QW-1:DW]};
            OP_T0:    r = {{(OPW-TCH){1'b0}}, t[0 +: TCH]};
            OP_T1:    r = {{(OPW-TCH){1'b0}}, t[TCH +: TCH]};
            OP_T2:    r = {{(OPW-TCH){1'b0}}, t[2*TCH +: TCH]};
            OP_T3:    r = {{(OPW-TCH){t[TW-1]}}, t[TW-1 -: TCH]};
            OP_EPS:   r = OPW'(pimp_pkg::EPS_RECIP);
            default:  r = '0;
        endcase
        return r;
    endfunction

    assign pop       = (state_reg == S_IDLE) && !empty;
    assign ctl_issue = step_ctl(step_reg);
    assign op_a      = sel_op(ctl_issue.a_sel, tri_reg, qx_reg, qy_reg, qz_reg, t_reg);
    assign op_b      = sel_op(ctl_issue.b_sel, tri_reg, qx_reg, qy_reg, qz_reg, t_reg);
    assign prod      = op_a * op_b;

    // sign-adjusted edge tests
    always_comb
    begin
        detneg    = det_reg[QW-1];
        det_ext   = {{2{det_reg[QW-1]}}, det_reg};
        adet      = detneg ? -det_ext : det_ext;
        uadj      = detneg ? -$signed({{2{u_reg[QW-1]}}, u_reg})
                           : $signed({{2{u_reg[QW-1]}}, u_reg});
        vadj      = detneg ? -$signed({{2{qx_reg[QW-1]}}, qx_reg})
                           : $signed({{2{qx_reg[QW-1]}}, qx_reg});
        uv_sum    = uadj + vadj;
        pass_next = ($unsigned(adet) >= (QW+2)'(pimp_pkg::DET_MIN))
                 && !uadj[QW+1] && !(uadj > adet)
                 && !vadj[QW+1] && !(uv_sum > adet);
    end

    // accumulate stage
    always_comb
    begin
        if (ctl_reg.use_adet)
        begin
            term = ACCW'(adet) <<< pimp_pkg::FRAC;
        end
        else
        begin
            unique case (ctl_reg.sh)
                SH_Q:    term = ACCW'(prod_reg) <<< DW;
                SH_T1:   term = ACCW'(prod_reg) <<< TCH;
                SH_T2:   term = ACCW'(prod_reg) <<< (2 * TCH);
                SH_T3:   term = ACCW'(prod_reg) <<< (3 * TCH);
                default: term = ACCW'(prod_reg);
            endcase
        end
        if (!ctl_reg.add_en)
        begin
            acc_next = acc_reg;
        end
        else if (ctl_reg.neg ^ (ctl_reg.negdet & detneg))
        begin
            acc_next = (ctl_reg.clr ? '0 : acc_reg) - term;
        end
        else
        begin
            acc_next = (ctl_reg.clr ? '0 : acc_reg) + term;
        end
    end

    always_comb
    begin
        hit      = pass_reg && d_pos_reg;
        fin_last = (state_reg == S_FIN) && tri_reg.last;
        out_busy = out_valid_reg && out_stall;
        cnt_next = (hit && (cnt_reg != '1)) ? cnt_reg + 1'b1 : cnt_reg;
        par_next = par_reg ^ hit;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod;
        acc_reg  <= acc_next;
        pass_reg <= pass_next;
        if (pop)
        begin
            tri_reg <= rd_data;
        end
        unique case (ctl_reg.dst)
            DST_DET: det_reg   <= acc_next[QW-1:0];
            DST_U:   u_reg     <= acc_next[QW-1:0];
            DST_QX:  qx_reg    <= acc_next[QW-1:0];
            DST_QY:  qy_reg    <= acc_next[QW-1:0];
            DST_QZ:  qz_reg    <= acc_next[QW-1:0];
            DST_T:   t_reg     <= acc_next[TW-1:0];
            DST_D:   d_pos_reg <= !acc_next[ACCW-1] && (acc_next != '0);
            default: ;
        endcase
        if (fin_last && !out_busy)
        begin
            inside_reg <= par_next;
            count_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            ctl_reg       <= step_ctl(5'd16);
            cnt_reg       <= '0;
            par_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // a new result may load in the cycle the old one is taken
            if (fin_last && !out_busy)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == S_RUN)
            begin
                ctl_reg <= ctl_issue;
            end
            else
            begin
                ctl_reg <= step_ctl(5'd16);
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    step_reg <= '0;
                    if (pop)
                    begin
                        state_reg <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == LAST_STEP)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (!tri_reg.last)
                    begin
                        cnt_reg   <= cnt_next;
                        par_reg   <= par_next;
                        state_reg <= S_IDLE;
                    end
                    else if (!out_busy)
                    begin
                        cnt_reg   <= '0;
                        par_reg   <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign inside_res = inside_reg;
    assign hit_count  = count_reg;

    `PIMP_ASSERT_IMPL(a_pop_only_idle, pop, state_reg == S_IDLE, "pop outside idle")
    `PIMP_ASSERT_NEXT(a_fin_holds, fin_last && out_busy, state_reg == S_FIN,
                      "last item left while result blocked")
    `PIMP_ASSERT_IMPL(a_result_from_last, $rose(out_valid_reg),
                      $past(state_reg) == S_FIN && $past(tri_reg.last),
                      "result without last item")
    `PIMP_ASSERT_NEXT(a_count_saturates, cnt_reg == '1, cnt_reg == '1 || cnt_reg == '0,
                      "hit counter wrapped")

endmodule

>>> src/point_in_mesh_parity_top.sv
// Top level of the point-in-mesh parity block.
// Depends on pimp_pkg, pimp_front, pimp_queue and pimp_back.
//
// Usage:
//  - Write point_x/y/z (index 0/1/2) on cfg_we/cfg_index/cfg_data while idle.
//  - Triangles enter on in_valid/in_stall, nine Q16.16 vertex coordinates
//    plus last_triangle. Each is tested against a +X ray from the point.
//  - Each item passes through the back end in order: it is popped, then
//    runs 22 micro-ops on the single shared 35x35 multiplier, then drains
//    and commits. It pops no new item until it is done with the last.
//  - A two-entry queue sits behind the input, so up to two items are
//    taken while the back end is busy; in_stall rises when it is full.
//  - On the item with last_triangle set, one result (inside_res = hit
//    parity, hit_count saturating) appears on out_valid once the back
//    end commits that item, and the counter and parity clear.
//  - The result register holds while out_stall is high; a second last
//    item waits in the back end until the first result is taken.
//  - Reset clears the point to zero, the queue, counter and parity.
module point_in_mesh_parity_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [pimp_pkg::PORT_W-1:0]   cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [pimp_pkg::PORT_W-1:0]   vert0_x,
    input  logic [pimp_pkg::PORT_W-1:0]   vert0_y,
    input  logic [pimp_pkg::PORT_W-1:0]   vert0_z,
    input  logic [pimp_pkg::PORT_W-1:0]   vert1_x,
    input  logic [pimp_pkg::PORT_W-1:0]   vert1_y,
    input  logic [pimp_pkg::PORT_W-1:0]   vert1_z,
    input  logic [pimp_pkg::PORT_W-1:0]   vert2_x,
    input  logic [pimp_pkg::PORT_W-1:0]   vert2_y,
    input  logic [pimp_pkg::PORT_W-1:0]   vert2_z,
    input  logic                          last_triangle,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          inside_res,
    output logic [pimp_pkg::CNT_W-1:0]    hit_count
);

    pimp_pkg::tri_t wr_data;
    pimp_pkg::tri_t rd_data;
    logic           q_full;
    logic           q_empty;
    logic           push;
    logic           pop;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    pimp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .vert0_x       (vert0_x),
        .vert0_y       (vert0_y),
        .vert0_z       (vert0_z),
        .vert1_x       (vert1_x),
        .vert1_y       (vert1_y),
        .vert1_z       (vert1_z),
        .vert2_x       (vert2_x),
        .vert2_y       (vert2_y),
        .vert2_z       (vert2_z),
        .last_triangle (last_triangle),
        .tri_out       (wr_data)
    );

    pimp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (wr_data),
        .pop     (pop),
        .rd_data (rd_data),
        .full    (q_full),
        .empty   (q_empty)
    );

    pimp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_data    (rd_data),
        .empty      (q_empty),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .inside_res (inside_res),
        .hit_count  (hit_count)
    );

endmodule

>>> verif/testbench.sv
// Testbench for point_in_mesh_parity_top: streams triangles against a +X ray
// and checks inside flag and hit count against a wide-integer predictor.
// Depends on pimp_pkg and the point_in_mesh_parity_top RTL.
`timescale 1ns / 1ps

module testbench;

    localparam logic [1:0] BAD_IDX = 2'd3;
    localparam int SETTLE = 60;
    localparam logic signed [191:0] W_EPS  = 192'sd100000;
    localparam logic signed [191:0] W_ONE2 = 192'sd1 << (2 * pimp_pkg::FRAC);
    localparam logic signed [191:0] W_ONE  = 192'sd1 << pimp_pkg::FRAC;

    typedef struct packed {
        logic                       inside_flag;
        logic [pimp_pkg::CNT_W-1:0] count;
    } verdict_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [1:0]                    cfg_index = '0;
    logic [pimp_pkg::PORT_W-1:0]   cfg_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic [pimp_pkg::PORT_W-1:0]   vert0_x = '0, vert0_y = '0, vert0_z = '0;
    logic [pimp_pkg::PORT_W-1:0]   vert1_x = '0, vert1_y = '0, vert1_z = '0;
    logic [pimp_pkg::PORT_W-1:0]   vert2_x = '0, vert2_y = '0, vert2_z = '0;
    logic                          last_triangle = 1'b0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic                          inside_res;
    logic [pimp_pkg::CNT_W-1:0]    hit_count;

    point_in_mesh_parity_top u_dut (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // predictor state
    logic [31:0]                query_pt [3];
    logic [pimp_pkg::CNT_W-1:0] hits_so_far;
    bit                         hit_par;
    verdict_t                   pending_verdicts [$];
    int                         errors = 0;
    bit                         stall_on = 1'b0;

    function automatic logic signed [191:0] wx(input logic [31:0] c);
        return {{160{c[31]}}, c};
    endfunction

    function automatic bit ray_crosses(input logic [31:0] c [9]);
        logic signed [191:0] v0x, v0y, v0z, e1x, e1y, e1z, e2x, e2y, e2z;
        logic signed [191:0] sx, sy, sz, det, adet, u, v, qx, qy, qz, t;
        bit neg;
        v0x = wx(c[0]); v0y = wx(c[1]); v0z = wx(c[2]);
        e1x = wx(c[3]) - v0x; e1y = wx(c[4]) - v0y; e1z = wx(c[5]) - v0z;
        e2x = wx(c[6]) - v0x; e2y = wx(c[7]) - v0y; e2z = wx(c[8]) - v0z;
        sx = wx(query_pt[0]) - v0x;
        sy = wx(query_pt[1]) - v0y;
        sz = wx(query_pt[2]) - v0z;
        det = e1z * e2y - e1y * e2z;
        neg = det < 0;
        adet = neg ? -det : det;
        if (adet * W_EPS < W_ONE2)
            return 0;
        u = sz * e2y - sy * e2z;
        if (neg)
            u = -u;
        if (u < 0 || u > adet)
            return 0;
        qx = sy * e1z - sz * e1y;
        qy = sz * e1x - sx * e1z;
        qz = sx * e1y - sy * e1x;
        v = neg ? -qx : qx;
        if (v < 0 || u + v > adet)
            return 0;
        t = e2x * qx + e2y * qy + e2z * qz;
        if (neg)
            t = -t;
        return adet * W_ONE < t * W_EPS;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx != BAD_IDX)
            query_pt[idx] = val;
        @(posedge clk);
    endtask

    task automatic send_tri(input logic [31:0] c [9], input bit last, input int gap);
        verdict_t vd;
        in_valid      <= 1'b1;
        vert0_x <= c[0]; vert0_y <= c[1]; vert0_z <= c[2];
        vert1_x <= c[3]; vert1_y <= c[4]; vert1_z <= c[5];
        vert2_x <= c[6]; vert2_y <= c[7]; vert2_z <= c[8];
        last_triangle <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (ray_crosses(c))
        begin
            if (hits_so_far != {pimp_pkg::CNT_W{1'b1}})
                hits_so_far++;
            hit_par = ~hit_par;
        end
        if (last)
        begin
            vd.inside_flag = hit_par;
            vd.count       = hits_so_far;
            pending_verdicts.insert(pending_verdicts.size(), vd);
            hits_so_far = '0;
            hit_par = 1'b0;
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        if (in_valid)
            in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // triangle with vertices mostly ahead of the point, scattered around the ray
    task automatic aimed_tri(output logic [31:0] c [9]);
        int spread;
        spread = ($urandom_range(3) == 0) ? (1 << 22) : (1 << 18);
        for (int i = 0; i < 3; i++)
        begin
            c[3*i]   = query_pt[0] + $urandom_range(1 << 20) - (1 << 17);
            c[3*i+1] = query_pt[1] + $urandom_range(2 * spread) - spread;
            c[3*i+2] = query_pt[2] + $urandom_range(2 * spread) - spread;
        end
    endtask

    task automatic noise_tri(output logic [31:0] c [9]);
        for (int i = 0; i < 9; i++)
            c[i] = $urandom();
    endtask

    task automatic test_directed();
        logic [31:0] c [9];
        // facing triangle, both windings
        c = '{32'h0001_0000, 32'hFFFF_0000, 32'hFFFF_0000,
              32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000,
              32'h0001_0000, 32'h0000_0000, 32'h0001_0000};
        send_tri(c, 0, gap_len());
        c = '{32'h0002_0000, 32'hFFFF_0000, 32'hFFFF_0000,
              32'h0002_0000, 32'h0000_0000, 32'h0001_0000,
              32'h0002_0000, 32'h0001_0000, 32'hFFFF_0000};
        send_tri(c, 1, gap_len());
        // behind the point
        c = '{32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000,
              32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_0000,
              32'hFFFF_0000, 32'h0000_0000, 32'h0001_0000};
        send_tri(c, 1, gap_len());
        // degenerate: collinear, then a tiny determinant
        c = '{32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
              32'h0001_0000, 32'h0002_0000, 32'h0002_0000};
        send_tri(c, 0, gap_len());
        c = '{32'h0001_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0001_0000, 32'h1, 32'h0,
              32'h0001_0000, 32'h0, 32'h1};
        send_tri(c, 1, gap_len());
        // empty-hit mesh of one
        c = '{default: 32'h0};
        send_tri(c, 1, gap_len());
        // extremes of the coordinates
        c = '{default: 32'h7FFF_FFFF};
        send_tri(c, 0, gap_len());
        c = '{default: 32'h8000_0000};
        send_tri(c, 0, gap_len());
        c = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF};
        send_tri(c, 1, gap_len());
        c = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        send_tri(c, 1, gap_len());
        drain();
    endtask

    task automatic test_config();
        logic [31:0] c [9];
        logic [31:0] pts [4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF};
        for (int k = 0; k < 4; k++)
        begin
            write_reg(pimp_pkg::REG_POINT_X, pts[k]);
            write_reg(pimp_pkg::REG_POINT_Y, pts[(k + 1) % 4]);
            write_reg(pimp_pkg::REG_POINT_Z, pts[(k + 2) % 4]);
            write_reg(BAD_IDX, $urandom());
            for (int n = 0; n < 4; n++)
            begin
                if (n[0])
                    noise_tri(c);
                else
                    aimed_tri(c);
                send_tri(c, n == 3, gap_len());
            end
            drain();
        end
    endtask

    task automatic test_random();
        logic [31:0] c [9];
        int left, mesh;
        for (int ph = 0; ph < 7; ph++)
        begin
            write_reg(pimp_pkg::REG_POINT_X, (ph == 0) ? 32'h0 : $urandom());
            write_reg(pimp_pkg::REG_POINT_Y, $urandom());
            write_reg(pimp_pkg::REG_POINT_Z, $urandom_range(1 << 24) - (1 << 23));
            if (ph == 3)
                write_reg(BAD_IDX, $urandom());
            stall_on = ph != 2;
            left = 100;
            while (left > 0)
            begin
                mesh = $urandom_range(12, 1);
                for (int n = 0; n < mesh && left > 0; n++)
                begin
                    if ($urandom_range(9) < 7)
                        aimed_tri(c);
                    else
                        noise_tri(c);
                    left--;
                    send_tri(c, n == mesh - 1 || left == 0,
                             (ph == 4) ? 0 : gap_len());
                end
                // now and then, hold the sender until the block has answered everything
                if ($urandom_range(7) == 0)
                begin
                    if (in_valid)
                        in_valid <= 1'b0;
                    while (pending_verdicts.size() != 0)
                        @(posedge clk);
                end
            end
            drain();
        end
    endtask

    // receiver stall pattern
    int stall_left = 0;
    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left <= stall_left - 1;
        else if (stall_on && $urandom_range(3) == 0)
            stall_left <= ($urandom_range(9) == 0) ? $urandom_range(40, 10)
                                                   : $urandom_range(3, 1);
        out_stall <= stall_on && (stall_left > 1 || (stall_left == 0 && 1'b0));
    end

    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_verdicts.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result inside=%0b count=%0d",
                         $time, inside_res, hit_count);
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (inside_res !== want.inside_flag)
                begin
                    errors++;
                    $display("%0t: inside_res expected %0b actual %0b",
                             $time, want.inside_flag, inside_res);
                end
                if (hit_count !== want.count)
                begin
                    errors++;
                    $display("%0t: hit_count expected %0d actual %0d",
                             $time, want.count, hit_count);
                end
            end
        end
    end

    initial
    begin
        #40_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        query_pt = '{default: 32'h0};
        hits_so_far = '0;
        hit_par = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        stall_on = 1'b1;
        test_directed();
        test_config();
        test_random();
        drain();
        if (errors == 0 && pending_verdicts.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
